>>> src/mpct_pkg.sv
// shared types and constants for the mouse packet cursor tracker
package mpct_pkg;

    localparam int DATA_BITS    = 8;
    localparam int CFG_BITS     = 13;
    localparam int CFG_IDX_BITS = 8;
    localparam int OUT_BITS     = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = CFG_BITS'(768);

    localparam int POS_X_RST = 512;
    localparam int POS_Y_RST = 384;

    // header bit positions
    localparam int HDR_LEFT_BIT  = 0;
    localparam int HDR_RIGHT_BIT = 1;
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_X   = 2'd1,
        PH_Y   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } t_screen;

    typedef struct packed {
        logic                 vld;
        logic [DATA_BITS-1:0] data_byte;
    } t_in_word;

endpackage

>>> src/mpct_ifs.sv
// handshake channel interfaces for the mouse packet cursor tracker
interface mpct_byte_if;
    import mpct_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface mpct_cursor_if;
    import mpct_pkg::*;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] cursor_x;
    logic [OUT_BITS-1:0] cursor_y;
    logic                left_button;
    logic                right_button;

    modport source (output valid, output cursor_x, output cursor_y,
                    output left_button, output right_button, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input left_button, input right_button, output ready);
endinterface

interface mpct_cfg_if;
    import mpct_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> src/mouse_packet_cursor_tracker.sv
// top level of the mouse packet cursor tracker
//
//   channel    dir  handshake        word
//   i_byte     in   valid / ready    data_byte[7:0]
//   o_cursor   out  valid / ready    cursor_x[11:0] cursor_y[11:0] left_button right_button
//   i_cfg      in   valid / ready    index[7:0] wdata[12:0], always ready
//
// one byte per cycle unless a waiting result stalls it; a byte is held in the
// input register, and the third byte of a packet is applied and clamped into
// the position registers, so a result is valid the cycle after its last byte is taken.
// reset is synchronous: phase to header hunt, cursor to 512 / 384, sizes 1024 / 768.
// a waiting result stalls only the byte that would complete the next packet.
module mouse_packet_cursor_tracker
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mpct_byte_if.sink       i_byte,
    mpct_cfg_if.sink        i_cfg,
    mpct_cursor_if.source   o_cursor
);

    t_screen  screen;
    t_in_word word;
    logic     take;

    mpct_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_screen (screen)
    );

    mpct_input_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_take  (take),
        .o_word  (word)
    );

    mpct_cursor_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (word),
        .i_screen (screen),
        .o_take   (take),
        .o_cursor (o_cursor)
    );

endmodule

>>> src/mpct_cfg_regs.sv
// screen size configuration registers
module mpct_cfg_regs
    import mpct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mpct_cfg_if.sink        i_cfg,
    output t_screen         o_screen
);

    t_screen r_screen;

    assign i_cfg.ready = 1'b1;
    assign o_screen    = r_screen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen.width  <= SCREEN_WIDTH_RST;
            r_screen.height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            // unknown indexes are dropped
            if (i_cfg.index == REG_SCREEN_WIDTH) begin
                r_screen.width <= i_cfg.wdata;
            end
            if (i_cfg.index == REG_SCREEN_HEIGHT) begin
                r_screen.height <= i_cfg.wdata;
            end
        end
    end

endmodule

>>> src/mpct_input_stage.sv
// input register for incoming mouse bytes
module mpct_input_stage
    import mpct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mpct_byte_if.sink       i_byte,
    input  logic            i_take,
    output t_in_word        o_word
);

    logic                 r_vld;
    logic [DATA_BITS-1:0] r_data;

    assign i_byte.ready     = !r_vld || i_take;
    assign o_word.vld       = r_vld;
    assign o_word.data_byte = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_byte.valid && i_byte.ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_data <= i_byte.data_byte;
        end
    end

endmodule

>>> src/mpct_cursor_core.sv
// packet assembly, delta apply and clamp, result register
module mpct_cursor_core
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_in_word        i_word,
    input  t_screen         i_screen,
    output logic            o_take,
    mpct_cursor_if.source   o_cursor
);

    localparam int SW = COORD_BITS + 2;
    localparam int CW = (COORD_BITS + 1 > CFG_BITS) ? COORD_BITS + 1 : CFG_BITS;
    localparam logic [CW-1:0]         MAX_COORD = CW'((1 << COORD_BITS) - 1);
    localparam logic [COORD_BITS-1:0] POS_X_INIT = COORD_BITS'(POS_X_RST);
    localparam logic [COORD_BITS-1:0] POS_Y_INIT = COORD_BITS'(POS_Y_RST);

    t_phase                r_phase, n_phase;
    logic [DATA_BITS-1:0]  r_hdr, n_hdr;
    logic [DATA_BITS-1:0]  r_xd, n_xd;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y;
    logic                  r_left, r_right;
    logic                  r_out_vld;
    logic                  emit;

    logic signed [8:0]     dx, dy;
    logic signed [SW-1:0]  nx, ny;
    logic [COORD_BITS-1:0] cx, cy;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SW-1:0] v,
        input logic [CFG_BITS-1:0]  size
    );
        logic [CW-1:0] size_m1;
        logic [CW-1:0] lim_m1;
        logic [CW-1:0] v_u;
        begin
            // zero size behaves as one
            size_m1 = (size == '0) ? '0 : CW'(size) - CW'(1);
            lim_m1  = (size_m1 > MAX_COORD) ? MAX_COORD : size_m1;
            v_u     = CW'(v[SW-2:0]);
            if (v[SW-1]) begin
                clamp_coord = '0;
            end else if (v_u > lim_m1) begin
                clamp_coord = lim_m1[COORD_BITS-1:0];
            end else begin
                clamp_coord = v_u[COORD_BITS-1:0];
            end
        end
    endfunction

    // a byte may move on unless it completes a packet while a result waits
    assign o_take = i_word.vld && (r_phase != PH_Y || !r_out_vld || o_cursor.ready);

    assign dx = $signed({r_hdr[HDR_XSIGN_BIT], r_xd});
    assign dy = $signed({r_hdr[HDR_YSIGN_BIT], i_word.data_byte});
    assign nx = $signed({2'b00, r_pos_x}) + SW'(dx);
    assign ny = $signed({2'b00, r_pos_y}) - SW'(dy);
    assign cx = clamp_coord(nx, i_screen.width);
    assign cy = clamp_coord(ny, i_screen.height);

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_xd    = r_xd;
        emit    = 1'b0;
        case (r_phase)
            PH_X: begin
                if (o_take) begin
                    n_xd    = i_word.data_byte;
                    n_phase = PH_Y;
                end
            end
            PH_Y: begin
                if (o_take) begin
                    emit    = 1'b1;
                    n_phase = PH_HDR;
                end
            end
            default: begin
                // hunt for a byte with the sync bit set
                if (o_take) begin
                    if (i_word.data_byte[HDR_SYNC_BIT]) begin
                        n_hdr   = i_word.data_byte;
                        n_phase = PH_X;
                    end else begin
                        n_phase = PH_HDR;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_hdr     <= '0;
            r_xd      <= '0;
            r_pos_x   <= POS_X_INIT;
            r_pos_y   <= POS_Y_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_xd    <= n_xd;
            if (emit) begin
                r_pos_x   <= cx;
                r_pos_y   <= cy;
                r_out_vld <= 1'b1;
            end else if (o_cursor.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_left  <= r_hdr[HDR_LEFT_BIT];
            r_right <= r_hdr[HDR_RIGHT_BIT];
        end
    end

    // position registers double as the result word
    assign o_cursor.valid        = r_out_vld;
    assign o_cursor.cursor_x     = OUT_BITS'(r_pos_x);
    assign o_cursor.cursor_y     = OUT_BITS'(r_pos_y);
    assign o_cursor.left_button  = r_left;
    assign o_cursor.right_button = r_right;

`ifndef SYNTH
    a_emit_after_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_phase == PH_Y))
        else $error("result raised outside the third byte");

    a_x_then_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == PH_X) |=> (r_phase == PH_Y))
        else $error("x byte did not advance to y phase");

    a_no_sync_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == PH_HDR && !i_word.data_byte[HDR_SYNC_BIT])
        |=> (r_phase == PH_HDR))
        else $error("byte without sync bit taken as header");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_cursor.ready) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("cursor moved while result was stalled");
`endif

endmodule
